// File: design/ssp_pkg.sv
package ssp_pkg;

	// default sizes
	localparam int unsigned NAME_LEN_DEF     = 5;
	localparam int unsigned PARAM_DIGITS_DEF = 8;

	// longest name the matcher compares, and number of known names
	localparam int unsigned NAME_MAX  = 8;
	localparam int unsigned NUM_KNOWN = 3;

	// digits taken into the message id
	localparam logic [1:0] ID_DIGITS = 2'd2;

	// characters
	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_COMMA  = 8'h2c;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_UA     = 8'h41;
	localparam logic [7:0] CHAR_UF     = 8'h46;
	localparam logic [7:0] CHAR_LA     = 8'h61;
	localparam logic [7:0] CHAR_LF     = 8'h66;
	localparam logic [7:0] HEX_TEN     = 8'd10;

	// known sentence names, padded with zero bytes
	localparam logic [7:0] KNOWN_NAMES [NUM_KNOWN][NAME_MAX] = '{
		'{8'h43, 8'h4e, 8'h54, 8'h52, 8'h4c, 8'h00, 8'h00, 8'h00},  // CNTRL
		'{8'h41, 8'h43, 8'h53, 8'h54, 8'h43, 8'h00, 8'h00, 8'h00},  // ACSTC
		'{8'h44, 8'h45, 8'h50, 8'h54, 8'h48, 8'h00, 8'h00, 8'h00}   // DEPTH
	};

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_CNTRL = 2'd1,
		KIND_ACSTC = 2'd2,
		KIND_DEPTH = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_WAIT  = 3'd0,
		PH_NAME  = 3'd1,
		PH_ID    = 3'd2,
		PH_PARAM = 3'd3,
		PH_STAR  = 3'd4,
		PH_CSUM  = 3'd5
	} phase_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  id;
		logic [31:0] param;
		logic [7:0]  csum;
		logic        csum_ok;
	} result_t;

	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t r;
		r = '0;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			r.ok  = 1'b1;
			r.val = 4'(c - CHAR_ZERO);
		end else if (c >= CHAR_UA && c <= CHAR_UF) begin
			r.ok  = 1'b1;
			r.val = 4'(c - CHAR_UA + HEX_TEN);
		end else if (c >= CHAR_LA && c <= CHAR_LF) begin
			r.ok  = 1'b1;
			r.val = 4'(c - CHAR_LA + HEX_TEN);
		end
		return r;
	endfunction

endpackage

// File: design/ssp_name_match.sv
module ssp_name_match #(
	parameter int unsigned NAME_LEN = ssp_pkg::NAME_LEN_DEF
) (
	input  logic [7:0]      name_chars [NAME_LEN],
	output ssp_pkg::kind_t  kind
);
	import ssp_pkg::*;

	logic [7:0]           padded [NAME_MAX];
	logic [NUM_KNOWN-1:0] hit;

	// characters past the name length compare as zero
	for (genvar i = 0; i < NAME_MAX; i++) begin : g_pad
		if (i < NAME_LEN) begin : g_chr
			assign padded[i] = name_chars[i];
		end else begin : g_zero
			assign padded[i] = 8'h00;
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_KNOWN; k++) begin
			hit[k] = 1'b1;
			for (int i = 0; i < NAME_MAX; i++) begin
				if (padded[i] != KNOWN_NAMES[k][i]) begin
					hit[k] = 1'b0;
				end
			end
		end
	end

	// first hit wins
	always_comb begin
		kind = KIND_NONE;
		for (int k = NUM_KNOWN - 1; k >= 0; k--) begin
			if (hit[k]) begin
				kind = kind_t'(2'(k + 1));
			end
		end
	end

endmodule

// File: design/ssp_parser.sv
module ssp_parser #(
	parameter int unsigned NAME_LEN     = ssp_pkg::NAME_LEN_DEF,
	parameter int unsigned PARAM_DIGITS = ssp_pkg::PARAM_DIGITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       rx,
	output logic             emit,
	output ssp_pkg::result_t res
);
	import ssp_pkg::*;

	localparam int unsigned NCNT_W = $clog2(NAME_LEN + 1);
	localparam int unsigned PCNT_W = $clog2(PARAM_DIGITS + 1);

	phase_t              phase_q, phase_d;
	logic [NCNT_W-1:0]   name_cnt_q, name_cnt_d;
	logic [1:0]          id_cnt_q, id_cnt_d;
	logic [PCNT_W-1:0]   par_cnt_q, par_cnt_d;
	logic                hex_have_q, hex_have_d;
	logic [7:0]          xor_q, xor_d;
	kind_t               kind_q, kind_d;
	logic [7:0]          id_q, id_d;
	logic [31:0]         param_q, param_d;
	logic [7:0]          name_q [NAME_LEN];
	logic [7:0]          first_hex_q;
	logic [7:0]          cand [NAME_LEN];
	logic                name_wr;
	logic                hex_wr;
	kind_t               match_kind;
	hex_t                h1, h2;
	logic [7:0]          csum_v;

	// name as it stands with this character written in
	for (genvar i = 0; i < NAME_LEN; i++) begin : g_cand
		assign cand[i] = (name_cnt_q == NCNT_W'(i)) ? rx : name_q[i];
	end

	ssp_name_match #(.NAME_LEN(NAME_LEN)) u_match (
		.name_chars (cand),
		.kind       (match_kind)
	);

	// next state
	always_comb begin
		phase_d    = phase_q;
		name_cnt_d = name_cnt_q;
		id_cnt_d   = id_cnt_q;
		par_cnt_d  = par_cnt_q;
		hex_have_d = hex_have_q;
		xor_d      = xor_q;
		kind_d     = kind_q;
		id_d       = id_q;
		param_d    = param_q;
		name_wr    = 1'b0;
		hex_wr     = 1'b0;
		if (step) begin
			if (rx == CHAR_DOLLAR) begin
				phase_d    = PH_NAME;
				name_cnt_d = '0;
				id_cnt_d   = '0;
				par_cnt_d  = '0;
				hex_have_d = 1'b0;
				xor_d      = rx;
				kind_d     = KIND_NONE;
				id_d       = '0;
				param_d    = '0;
			end else begin
				unique case (phase_q)
					PH_NAME: begin
						xor_d = xor_q ^ rx;
						if (rx == CHAR_COMMA) begin
							phase_d = PH_ID;
						end else if (name_cnt_q < NCNT_W'(NAME_LEN)) begin
							name_wr    = 1'b1;
							name_cnt_d = name_cnt_q + NCNT_W'(1);
							if (name_cnt_q == NCNT_W'(NAME_LEN - 1)) begin
								kind_d = match_kind;
								if (match_kind == KIND_NONE) begin
									phase_d = PH_WAIT;
								end
							end
						end
					end
					PH_ID: begin
						xor_d = xor_q ^ rx;
						if (rx == CHAR_COMMA) begin
							phase_d = PH_PARAM;
						end else if (id_cnt_q < ID_DIGITS) begin
							id_d     = {id_q[4:0], 3'b000} + {id_q[6:0], 1'b0} + (rx - CHAR_ZERO);
							id_cnt_d = id_cnt_q + 2'd1;
						end
					end
					PH_PARAM: begin
						xor_d = xor_q ^ rx;
						if (rx == CHAR_COMMA) begin
							phase_d = PH_STAR;
						end else if (par_cnt_q < PCNT_W'(PARAM_DIGITS)) begin
							param_d   = {param_q[28:0], 3'b000} + {param_q[30:0], 1'b0}
								+ ({24'd0, rx} - {24'd0, CHAR_ZERO});
							par_cnt_d = par_cnt_q + PCNT_W'(1);
						end
					end
					PH_STAR: begin
						xor_d = xor_q ^ rx;
						if (rx == CHAR_COMMA) begin
							phase_d = PH_CSUM;
						end
					end
					PH_CSUM: begin
						if (!hex_have_q) begin
							hex_wr     = 1'b1;
							hex_have_d = 1'b1;
						end else begin
							phase_d = PH_WAIT;
						end
					end
					default: begin
						// waiting for start, and unused codes
					end
				endcase
			end
		end
	end

	// outputs
	always_comb begin
		h1   = hex_value(first_hex_q);
		h2   = hex_value(rx);
		emit = (rx != CHAR_DOLLAR) && (phase_q == PH_CSUM) && hex_have_q;
		if (!h1.ok) begin
			csum_v = '0;
		end else if (!h2.ok) begin
			csum_v = {4'd0, h1.val};
		end else begin
			csum_v = {h1.val, h2.val};
		end
		res.kind    = kind_q;
		res.id      = id_q;
		res.param   = param_q;
		res.csum    = csum_v;
		res.csum_ok = (csum_v == xor_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WAIT;
			name_cnt_q <= '0;
			id_cnt_q   <= '0;
			par_cnt_q  <= '0;
			hex_have_q <= 1'b0;
			xor_q      <= '0;
			kind_q     <= KIND_NONE;
			id_q       <= '0;
			param_q    <= '0;
		end else begin
			phase_q    <= phase_d;
			name_cnt_q <= name_cnt_d;
			id_cnt_q   <= id_cnt_d;
			par_cnt_q  <= par_cnt_d;
			hex_have_q <= hex_have_d;
			xor_q      <= xor_d;
			kind_q     <= kind_d;
			id_q       <= id_d;
			param_q    <= param_d;
		end
	end

	// name characters and first checksum character, no reset
	for (genvar i = 0; i < NAME_LEN; i++) begin : g_name
		always_ff @(posedge clk) begin
			if (name_wr && name_cnt_q == NCNT_W'(i)) begin
				name_q[i] <= rx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hex_wr) begin
			first_hex_q <= rx;
		end
	end

endmodule

// File: design/sensor_sentence_parser_unit.sv
// sensor sentence parser: takes one received character per item on the input
// channel (in_valid, in_ready, rx_byte) and parses sentences $NAME,ID,PARAM,*,HH
// with an xor checksum over everything from the dollar up to the last comma
// one result item per completed sentence appears on the output channel
// (out_valid, out_ready and the five result ports), also when the checksum fails
// sentences with an unknown five-letter name produce nothing
// a character accepted goes into the input stage; the item it completes is
// written into the result register when the parser takes that character,
// and shows on the outputs from there
// throughput: one character per cycle unless held, set by the single parse stage
// the input stage only holds when it carries a sentence-ending character and the
// result register is full and not being taken
// reset clears the parse state to waiting for a dollar and empties both stages
// when the receiver stalls, the result waits in the result register, the input
// stage keeps taking characters that finish no sentence, and in_ready drops only
// once a second sentence end is waiting behind the held result
module sensor_sentence_parser_unit #(
	parameter int unsigned NAME_LEN     = ssp_pkg::NAME_LEN_DEF,
	parameter int unsigned PARAM_DIGITS = ssp_pkg::PARAM_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  sensor_kind,
	output logic [7:0]  message_id,
	output logic [31:0] parameter_value,
	output logic [7:0]  received_checksum,
	output logic        checksum_ok
);
	import ssp_pkg::*;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	// result stage
	logic       valid_s2;
	result_t    result_s2;

	logic       emit;
	result_t    res;
	logic       adv_s1;
	logic       step;
	logic       in_take;

	// the input stage moves on unless it would finish a sentence into a full,
	// stalled result register
	assign adv_s1   = !emit || !valid_s2 || out_ready;
	assign step     = valid_s1 && adv_s1;
	assign in_ready = !valid_s1 || adv_s1;
	assign in_take  = in_valid && in_ready;

	ssp_parser #(
		.NAME_LEN     (NAME_LEN),
		.PARAM_DIGITS (PARAM_DIGITS)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.rx     (byte_s1),
		.emit   (emit),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_take || (valid_s1 && !adv_s1);
			if (step && emit) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= rx_byte;
		end
		if (step && emit) begin
			result_s2 <= res;
		end
	end

	assign out_valid         = valid_s2;
	assign sensor_kind       = result_s2.kind;
	assign message_id        = result_s2.id;
	assign parameter_value   = result_s2.param;
	assign received_checksum = result_s2.csum;
	assign checksum_ok       = result_s2.csum_ok;

endmodule

// File: design/ssp_checker.sv
module ssp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  sensor_kind,
	input logic [7:0]  message_id,
	input logic [31:0] parameter_value,
	input logic [7:0]  received_checksum,
	input logic        checksum_ok
);

	// reset empties the result register at once
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result item shown during reset");

	// a held result stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(sensor_kind) && $stable(message_id)
			&& $stable(parameter_value) && $stable(received_checksum)
			&& $stable(checksum_ok))
		else $error("stalled result item changed");

	// with the result register empty, the input side never stalls
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// a fresh result comes from an item taken on the input channel
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result item without a matching input item");

endmodule

bind sensor_sentence_parser_unit ssp_checker u_ssp_checker (.*);

// File: tb/ssp_tb_pkg.sv
package ssp_tb_pkg;
	import ssp_pkg::*;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  id;
		logic [31:0] param;
		logic [7:0]  csum;
		logic        csum_ok;
	} sentence_t;

	class sentence_checker;
		// own copy of the parse state
		phase_t      phase;
		int unsigned name_seen;
		logic [7:0]  name_buf [NAME_MAX];
		int unsigned id_seen;
		int unsigned param_seen;
		bit          hi_seen;
		logic [7:0]  hi_char;
		logic [7:0]  xor_acc;
		kind_t       kind;
		logic [7:0]  id_acc;
		logic [31:0] param_acc;

		sentence_t   expected_sentences [$];
		int unsigned predicted;
		int unsigned errors;
		int unsigned checked;
		int unsigned good_csum;
		int unsigned per_kind [4];

		function new();
			phase      = PH_WAIT;
			name_seen  = 0;
			id_seen    = 0;
			param_seen = 0;
			hi_seen    = 1'b0;
			hi_char    = '0;
			xor_acc    = '0;
			kind       = KIND_NONE;
			id_acc     = '0;
			param_acc  = '0;
			predicted  = 0;
			errors     = 0;
			checked    = 0;
			good_csum  = 0;
			foreach (name_buf[i]) name_buf[i] = '0;
			foreach (per_kind[i]) per_kind[i] = 0;
		endfunction

		function kind_t lookup_kind();
			logic [63:0] word;
			int          i;
			word = '0;
			for (i = 0; i < NAME_LEN_DEF; i++) word[63 - 8 * i -: 8] = name_buf[i];
			if (word == {"CNTRL", 24'h0}) return KIND_CNTRL;
			if (word == {"ACSTC", 24'h0}) return KIND_ACSTC;
			if (word == {"DEPTH", 24'h0}) return KIND_DEPTH;
			return KIND_NONE;
		endfunction

		// -1 for anything that is not a hex digit
		function int nibble_of(logic [7:0] c);
			if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c) - int'(CHAR_ZERO);
			if (c >= CHAR_UA && c <= CHAR_UF) return int'(c) - int'(CHAR_UA) + 10;
			if (c >= CHAR_LA && c <= CHAR_LF) return int'(c) - int'(CHAR_LA) + 10;
			return -1;
		endfunction

		function void note_byte(logic [7:0] b);
			int        hi;
			int        lo;
			logic [7:0] v;
			sentence_t rec;
			if (b == CHAR_DOLLAR) begin
				xor_acc    = b;
				name_seen  = 0;
				id_seen    = 0;
				param_seen = 0;
				hi_seen    = 1'b0;
				kind       = KIND_NONE;
				id_acc     = '0;
				param_acc  = '0;
				phase      = PH_NAME;
				return;
			end
			case (phase)
				PH_NAME: begin
					xor_acc ^= b;
					if (b == CHAR_COMMA) begin
						phase = PH_ID;
					end else begin
						if (name_seen < NAME_LEN_DEF) begin
							name_buf[name_seen] = b;
							name_seen++;
						end
						if (name_seen == NAME_LEN_DEF) begin
							kind = lookup_kind();
							if (kind == KIND_NONE) phase = PH_WAIT;
						end
					end
				end
				PH_ID: begin
					xor_acc ^= b;
					if (b == CHAR_COMMA) begin
						phase = PH_PARAM;
					end else if (id_seen < ID_DIGITS) begin
						id_acc = id_acc * 8'd10 + (b - CHAR_ZERO);
						id_seen++;
					end
				end
				PH_PARAM: begin
					xor_acc ^= b;
					if (b == CHAR_COMMA) begin
						phase = PH_STAR;
					end else if (param_seen < PARAM_DIGITS_DEF) begin
						param_acc = param_acc * 32'd10 + {24'h0, b} - {24'h0, CHAR_ZERO};
						param_seen++;
					end
				end
				PH_STAR: begin
					xor_acc ^= b;
					if (b == CHAR_COMMA) phase = PH_CSUM;
				end
				PH_CSUM: begin
					if (!hi_seen) begin
						hi_char = b;
						hi_seen = 1'b1;
					end else begin
						hi = nibble_of(hi_char);
						lo = nibble_of(b);
						v  = '0;
						if (hi >= 0) begin
							v = 8'(hi);
							if (lo >= 0) v = 8'(hi * 16 + lo);
						end
						rec.kind    = kind;
						rec.id      = id_acc;
						rec.param   = param_acc;
						rec.csum    = v;
						rec.csum_ok = (v == xor_acc);
						expected_sentences.push_back(rec);
						predicted++;
						phase = PH_WAIT;
					end
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_result(sentence_t got);
			sentence_t want;
			if (expected_sentences.size() == 0) begin
				report($sformatf("unexpected item: kind %0d id %0d param %0d csum %h ok %b",
					got.kind, got.id, got.param, got.csum, got.csum_ok));
				return;
			end
			want = expected_sentences.pop_front();
			checked++;
			per_kind[want.kind]++;
			if (want.csum_ok) good_csum++;
			if (got.kind !== want.kind)
				report($sformatf("item %0d kind %0d, want %0d", checked, got.kind, want.kind));
			if (got.id !== want.id)
				report($sformatf("item %0d id %0d, want %0d", checked, got.id, want.id));
			if (got.param !== want.param)
				report($sformatf("item %0d param %0d, want %0d", checked, got.param, want.param));
			if (got.csum !== want.csum)
				report($sformatf("item %0d csum %h, want %h", checked, got.csum, want.csum));
			if (got.csum_ok !== want.csum_ok)
				report($sformatf("item %0d csum_ok %b, want %b", checked, got.csum_ok,
					want.csum_ok));
		endtask

		function int unsigned pending();
			return expected_sentences.size();
		endfunction
	endclass

endpackage

// File: tb/sensor_sentence_parser_unit_tb.sv
module sensor_sentence_parser_unit_tb;
	import ssp_pkg::*;
	import ssp_tb_pkg::*;

	// generous ceiling on the whole run, in clock cycles
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned RANDOM_BYTES = 850;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  sensor_kind;
	logic [7:0]  message_id;
	logic [31:0] parameter_value;
	logic [7:0]  received_checksum;
	logic        checksum_ok;

	sentence_checker sentences;

	// line under construction and the xor a correct checksum must carry
	logic [7:0]  line_q [$];
	logic [7:0]  line_xor;
	// calm stretches: no gaps on either side
	bit          calm;
	int unsigned sent_bytes;
	int unsigned cycle_count;

	sensor_sentence_parser_unit u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.rx_byte           (rx_byte),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.sensor_kind       (sensor_kind),
		.message_id        (message_id),
		.parameter_value   (parameter_value),
		.received_checksum (received_checksum),
		.checksum_ok       (checksum_ok)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog: a hang anywhere ends the run as a failure
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_count,
				sentences.pending());
			$display("Some tests failed");
			$finish;
		end
	end

	// result monitor: every item taken off the output channel is checked in order
	always @(posedge clk) begin
		sentence_t got;
		if (arst_n && out_valid && out_ready) begin
			got.kind    = kind_t'(sensor_kind);
			got.id      = message_id;
			got.param   = parameter_value;
			got.csum    = received_checksum;
			got.csum_ok = checksum_ok;
			sentences.check_result(got);
		end
	end

	// receiver: mostly ready, short stalls often, long ones now and then
	initial begin
		int unsigned hold;
		hold      = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				out_ready = 1'b0;
				hold--;
			end else if (calm || $urandom_range(99) < 65) begin
				out_ready = 1'b1;
			end else begin
				out_ready = 1'b0;
				hold = ($urandom_range(99) < 85) ? $urandom_range(3, 0) : $urandom_range(40, 10);
			end
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm) return 0;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// one item on the input channel; valid only drops during a gap
	task automatic put_byte(input logic [7:0] b);
		int unsigned gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
			rx_byte  = 8'($urandom_range(255));
		end
		@(negedge clk);
		in_valid = 1'b1;
		rx_byte  = b;
		do @(posedge clk); while (!in_ready);
		sentences.note_byte(b);
	endtask

	// hold the sender until every expected result has been taken
	task automatic wait_until_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (sentences.pending() != 0) @(posedge clk);
		// a character that ends no sentence may still sit in the input stage
		repeat (4) @(posedge clk);
	endtask

	task automatic push_byte(input logic [7:0] b);
		line_q.push_back(b);
		if (b == CHAR_DOLLAR) line_xor = b;
		else line_xor ^= b;
	endtask

	task automatic push_str(input string s);
		int i;
		for (i = 0; i < s.len(); i++) push_byte(s[i]);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
		if (n < 4'd10) return CHAR_ZERO + 8'(n);
		if (lower) return CHAR_LA + 8'(n) - 8'd10;
		return CHAR_UA + 8'(n) - 8'd10;
	endfunction

	task automatic push_hex(input logic [7:0] v, input bit lower);
		push_byte(hex_char(v[7:4], lower));
		push_byte(hex_char(v[3:0], lower));
	endtask

	// any character that neither restarts a sentence nor closes a field
	function automatic logic [7:0] plain_byte();
		logic [7:0] r;
		do r = 8'($urandom_range(255)); while (r == CHAR_DOLLAR || r == CHAR_COMMA);
		return r;
	endfunction

	function automatic logic [7:0] field_char();
		if ($urandom_range(99) < 85) return CHAR_ZERO + 8'($urandom_range(9));
		return plain_byte();
	endfunction

	function automatic logic [7:0] letter();
		return CHAR_UA + 8'($urandom_range(25));
	endfunction

	task automatic send_line();
		int i;
		for (i = 0; i < line_q.size(); i++) put_byte(line_q[i]);
		line_q.delete();
	endtask

	// mostly well-formed sentences with random content, some noise and broken ones
	task automatic build_random_line();
		int unsigned r;
		int unsigned n;
		int unsigned cut;
		bit          lower;
		line_q.delete();
		if ($urandom_range(99) < 10) begin
			n = $urandom_range(6, 1);
			repeat (n) push_byte(8'($urandom_range(255)));
		end
		push_byte(CHAR_DOLLAR);
		r = $urandom_range(99);
		if (r < 75 || r >= 91) begin
			case ($urandom_range(2))
				0: push_str("CNTRL");
				1: push_str("ACSTC");
				default: push_str("DEPTH");
			endcase
			// extra name characters past the fifth
			if (r >= 91) begin
				n = $urandom_range(3, 1);
				repeat (n) push_byte(plain_byte());
			end
		end else if (r < 83) begin
			n = $urandom_range(4, 0);
			repeat (n) push_byte(letter());
		end else begin
			repeat (5) push_byte(letter());
		end
		push_byte(CHAR_COMMA);
		n = $urandom_range(4, 0);
		repeat (n) push_byte(field_char());
		push_byte(CHAR_COMMA);
		n = ($urandom_range(99) < 85) ? $urandom_range(8, 0) : $urandom_range(12, 9);
		repeat (n) push_byte(field_char());
		push_byte(CHAR_COMMA);
		r = $urandom_range(99);
		if (r < 80) begin
			push_str("*");
		end else if (r < 90) begin
			n = $urandom_range(3, 1);
			repeat (n) push_byte(plain_byte());
		end
		push_byte(CHAR_COMMA);
		r     = $urandom_range(99);
		lower = 1'($urandom_range(1));
		if (r < 70) begin
			push_hex(line_xor, lower);
		end else if (r < 82) begin
			push_hex(line_xor ^ 8'($urandom_range(255, 1)), lower);
		end else begin
			repeat (2) begin
				if ($urandom_range(1)) push_byte(hex_char(4'($urandom_range(15)), lower));
				else push_byte(plain_byte());
			end
		end
		// broken sentence: cut short, the next dollar restarts the parse
		if ($urandom_range(99) < 8) begin
			cut = $urandom_range(line_q.size() - 1, 1);
			while (line_q.size() > cut) void'(line_q.pop_back());
		end
	endtask

	initial begin
		int unsigned next_switch;
		sentences   = new();
		cycle_count = 0;
		sent_bytes  = 0;
		calm        = 1'b0;
		line_xor    = '0;
		in_valid    = 1'b0;
		rx_byte     = '0;
		arst_n      = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: each known name, digit extremes, both hex cases
		push_str("$CNTRL,12,345,*,");
		push_hex(line_xor, 1'b0);
		send_line();
		push_str("$ACSTC,99,99999999,*,");
		push_hex(line_xor, 1'b1);
		send_line();
		// failed checksum is still reported
		push_str("$DEPTH,0,0,*,");
		push_hex(line_xor ^ 8'h01, 1'b0);
		send_line();
		// short and empty names go on with no kind
		push_str("$AB,5,7,*,");
		push_hex(line_xor, 1'b0);
		send_line();
		push_str("$,,,,");
		push_hex(line_xor, 1'b0);
		send_line();
		// unknown name drops the sentence, nothing comes out
		push_str("$XXXXX,1,2,*,00");
		send_line();
		// extra name, id and parameter characters
		push_str("$DEPTHXY,123,1234567890,*,");
		push_hex(line_xor, 1'b1);
		send_line();
		// non-digits wrap the values, all-zero and all-one bytes
		push_str("$CNTRL,");
		push_byte(8'hff);
		push_byte(8'h00);
		push_byte(CHAR_COMMA);
		repeat (8) push_byte(8'hff);
		push_byte(8'h5a);
		push_str(",*,");
		push_hex(line_xor, 1'b1);
		send_line();
		// non-hex first character, then non-hex second character
		push_str("$ACSTC,1,1,*,G5");
		send_line();
		push_str("$ACSTC,1,1,*,5Z");
		send_line();
		// dollar mid-sentence and inside the checksum restarts the parse
		push_str("$CNTRL,4");
		push_str("$DEPTH,2,3,*,");
		push_hex(line_xor, 1'b0);
		send_line();
		push_str("$CNTRL,1,2,*,4");
		push_str("$ACSTC,,,,");
		push_hex(line_xor, 1'b1);
		send_line();
		// bytes while waiting for a start are ignored; junk in the star field
		push_str("abc,*9");
		push_str("$CNTRL,1,2,xyz*,");
		push_hex(line_xor, 1'b0);
		send_line();
		wait_until_drained();

		// random part, switching between calm and gappy stretches
		next_switch = 0;
		while (sent_bytes < RANDOM_BYTES) begin
			if (sent_bytes >= next_switch) begin
				next_switch += 150;
				calm = ($urandom_range(3) == 0);
				if ($urandom_range(1)) wait_until_drained();
			end
			build_random_line();
			sent_bytes += line_q.size();
			send_line();
		end

		calm = 1'b0;
		wait_until_drained();
		repeat (8) @(posedge clk);
		if (sentences.pending() != 0)
			sentences.report($sformatf("%0d results never arrived", sentences.pending()));

		$display("covered %0d sentence results: %0d cntrl, %0d acstc, %0d depth, %0d unnamed",
			sentences.checked, sentences.per_kind[KIND_CNTRL], sentences.per_kind[KIND_ACSTC],
			sentences.per_kind[KIND_DEPTH], sentences.per_kind[KIND_NONE]);
		$display("%0d of them with a matching checksum, %0d random characters, %0d mismatches",
			sentences.good_csum, sent_bytes, sentences.errors);
		if (sentences.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
